// ----- hdl/rne_pkg.sv -----
// Package: types, constants and control store of the Roman numeral encoder.
`default_nettype none

package rne_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymW    = 7;
  localparam int unsigned WeightW = 10;
  localparam int unsigned AddrW   = 5;

  localparam logic [ValueW-1:0] ValueMax = 12'd3999;

  localparam logic [SymW-1:0] SymNone = 7'h00;
  localparam logic [SymW-1:0] SymM    = 7'h4D;
  localparam logic [SymW-1:0] SymD    = 7'h44;
  localparam logic [SymW-1:0] SymC    = 7'h43;
  localparam logic [SymW-1:0] SymL    = 7'h4C;
  localparam logic [SymW-1:0] SymX    = 7'h58;
  localparam logic [SymW-1:0] SymV    = 7'h56;
  localparam logic [SymW-1:0] SymI    = 7'h49;

  localparam logic [AddrW-1:0] AddrStart = 5'd0;
  localparam logic [AddrW-1:0] AddrBad   = 5'd19;

  typedef enum logic [1:0] {
    OP_TEST = 2'd0,
    OP_EMIT = 2'd1,
    OP_BAD  = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              pair;
    logic [WeightW-1:0] weight;
    logic [SymW-1:0]    sym;
    logic [AddrW-1:0]   jmp_hit;
    logic [AddrW-1:0]   jmp_miss;
  } ctrl_t;

  function automatic ctrl_t mk(op_e op, logic pair, logic [WeightW-1:0] weight,
                               logic [SymW-1:0] sym, logic [AddrW-1:0] jmp_hit,
                               logic [AddrW-1:0] jmp_miss);
    ctrl_t w;
    w.op       = op;
    w.pair     = pair;
    w.weight   = weight;
    w.sym      = sym;
    w.jmp_hit  = jmp_hit;
    w.jmp_miss = jmp_miss;
    return w;
  endfunction

  function automatic ctrl_t rom_word(logic [AddrW-1:0] addr);
    ctrl_t w;
    unique case (addr)
      5'd0:    w = mk(OP_TEST, 1'b0, 10'd1000, SymM, 5'd0,  5'd1);
      5'd1:    w = mk(OP_TEST, 1'b1, 10'd900,  SymC, 5'd2,  5'd3);
      5'd2:    w = mk(OP_EMIT, 1'b0, 10'd0,    SymM, 5'd1,  5'd1);
      5'd3:    w = mk(OP_TEST, 1'b0, 10'd500,  SymD, 5'd3,  5'd4);
      5'd4:    w = mk(OP_TEST, 1'b1, 10'd400,  SymC, 5'd5,  5'd6);
      5'd5:    w = mk(OP_EMIT, 1'b0, 10'd0,    SymD, 5'd4,  5'd4);
      5'd6:    w = mk(OP_TEST, 1'b0, 10'd100,  SymC, 5'd6,  5'd7);
      5'd7:    w = mk(OP_TEST, 1'b1, 10'd90,   SymX, 5'd8,  5'd9);
      5'd8:    w = mk(OP_EMIT, 1'b0, 10'd0,    SymC, 5'd7,  5'd7);
      5'd9:    w = mk(OP_TEST, 1'b0, 10'd50,   SymL, 5'd9,  5'd10);
      5'd10:   w = mk(OP_TEST, 1'b1, 10'd40,   SymX, 5'd11, 5'd12);
      5'd11:   w = mk(OP_EMIT, 1'b0, 10'd0,    SymL, 5'd10, 5'd10);
      5'd12:   w = mk(OP_TEST, 1'b0, 10'd10,   SymX, 5'd12, 5'd13);
      5'd13:   w = mk(OP_TEST, 1'b1, 10'd9,    SymI, 5'd14, 5'd15);
      5'd14:   w = mk(OP_EMIT, 1'b0, 10'd0,    SymX, 5'd13, 5'd13);
      5'd15:   w = mk(OP_TEST, 1'b0, 10'd5,    SymV, 5'd15, 5'd16);
      5'd16:   w = mk(OP_TEST, 1'b1, 10'd4,    SymI, 5'd17, 5'd18);
      5'd17:   w = mk(OP_EMIT, 1'b0, 10'd0,    SymV, 5'd16, 5'd16);
      5'd18:   w = mk(OP_TEST, 1'b0, 10'd1,    SymI, 5'd18, 5'd18);
      default: w = mk(OP_BAD,  1'b0, 10'd0,    SymNone, AddrBad, AddrBad);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rne_in_if.sv -----
// Interface: request channel carrying the integer to encode.
`default_nettype none

interface rne_in_if;
  logic                       valid;
  logic                       ready;
  logic [rne_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/rne_out_if.sv -----
// Interface: result channel carrying one numeral character per request.
`default_nettype none

interface rne_out_if;
  logic                     valid;
  logic                     ready;
  logic [rne_pkg::SymW-1:0] symbol;
  logic                     last;
  logic                     invalid;

  modport source (output valid, output symbol, output last, output invalid, input ready);
  modport sink   (input valid, input symbol, input last, input invalid, output ready);
endinterface

`default_nettype wire

// ----- hdl/roman_numeral_encoder.sv -----
// Top level: microcoded integer to Roman numeral encoder.
//
// Usage:
//   in_i carries one integer (value) per request. While a numeral is being
//   produced in_i.ready is low; it rises again once the final character has
//   moved into the output register.
//   out_o carries one ASCII character per request, last marking the final one.
//   A value of 0 or above 3999 gives a single request with symbol 0, last 1
//   and invalid 1.
//   Timing: the sequencer reads one control word per cycle from its control
//   store, unless an emitting word waits for the output register. A word
//   either emits a character or tests a weight that does not fit and jumps
//   on. A value gives 15 characters at most; no new request is taken until
//   its final character is in the output register.
//   When the receiver stalls, the output register holds its character and the
//   sequencer holds on a word that emits; nothing is dropped.
//   Reset clears the sequencer and the output valid; the block comes up idle.
`default_nettype none

module roman_numeral_encoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  rne_in_if.sink      in_i,
  rne_out_if.source   out_o
);

  logic                           busy_q, busy_d;
  logic [rne_pkg::AddrW-1:0]      pc_q, pc_d;
  logic [rne_pkg::ValueW-1:0]     n_q, n_d;
  logic                           out_valid_q, out_valid_d;
  logic [rne_pkg::SymW-1:0]       sym_q;
  logic                           last_q;
  logic                           bad_q;

  rne_pkg::ctrl_t                 cw;
  logic [rne_pkg::ValueW:0]       diff;
  logic                           hit;
  logic                           emit;
  logic                           emit_last;
  logic                           slot_free;
  logic                           advance;
  logic                           in_acc;
  logic                           in_ok;

  assign cw        = rne_pkg::rom_word(pc_q);
  assign diff      = {1'b0, n_q} - {3'b000, cw.weight};
  assign hit       = ~diff[rne_pkg::ValueW];
  assign slot_free = ~out_valid_q | out_o.ready;

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    unique case (cw.op)
      rne_pkg::OP_TEST: begin
        emit      = hit;
        emit_last = ~cw.pair & (diff[rne_pkg::ValueW-1:0] == '0);
      end
      rne_pkg::OP_EMIT: begin
        emit      = 1'b1;
        emit_last = (n_q == '0);
      end
      rne_pkg::OP_BAD: begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      default: begin
        emit      = 1'b0;
        emit_last = 1'b0;
      end
    endcase
  end

  assign advance    = busy_q & (~emit | slot_free);
  assign in_i.ready = ~busy_q;
  assign in_acc     = in_i.valid & ~busy_q;
  assign in_ok      = (in_i.value != '0) & (in_i.value <= rne_pkg::ValueMax);

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    n_d         = n_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    if (in_acc) begin
      busy_d = 1'b1;
      n_d    = in_i.value;
      pc_d   = in_ok ? rne_pkg::AddrStart : rne_pkg::AddrBad;
    end else if (advance) begin
      if (emit) begin
        out_valid_d = 1'b1;
        pc_d        = cw.jmp_hit;
        if (cw.op == rne_pkg::OP_TEST) begin
          n_d = diff[rne_pkg::ValueW-1:0];
        end
        if (emit_last) begin
          busy_d = 1'b0;
        end
      end else begin
        pc_d = cw.jmp_miss;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= rne_pkg::AddrStart;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    if (advance && emit) begin
      sym_q  <= (cw.op == rne_pkg::OP_BAD) ? rne_pkg::SymNone : cw.sym;
      last_q <= emit_last;
      bad_q  <= (cw.op == rne_pkg::OP_BAD);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.symbol  = sym_q;
  assign out_o.last    = last_q;
  assign out_o.invalid = bad_q;

  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> last_q && (sym_q == rne_pkg::SymNone))
    else $error("invalid result must be a lone empty character");

  a_good_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !bad_q |-> (sym_q != rne_pkg::SymNone))
    else $error("valid result carries no character");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q)
    else $error("sequencer not started after request");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= rne_pkg::AddrBad))
    else $error("step counter outside control store");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (pc_q != rne_pkg::AddrBad) |-> (n_q <= rne_pkg::ValueMax))
    else $error("remainder out of range");

endmodule

`default_nettype wire

// ----- bench/rne_checker.sv -----
// Checker: predicts the Roman numeral of each request and compares every character.
`timescale 1ns / 1ps

module rne_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  rne_in_if           req_mon,
  rne_out_if          chr_mon,
  output int unsigned fails_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [rne_pkg::SymW-1:0] symbol;
    logic                     last;
    logic                     invalid;
  } glyph_t;

  glyph_t glyphs[$];

  function automatic void numeral_step(input int s, output int unsigned weight,
                                       output logic [rne_pkg::SymW-1:0] head,
                                       output logic [rne_pkg::SymW-1:0] tail);
    tail = rne_pkg::SymNone;
    case (s)
      0:       begin weight = 1000; head = rne_pkg::SymM; end
      1:       begin weight = 900;  head = rne_pkg::SymC; tail = rne_pkg::SymM; end
      2:       begin weight = 500;  head = rne_pkg::SymD; end
      3:       begin weight = 400;  head = rne_pkg::SymC; tail = rne_pkg::SymD; end
      4:       begin weight = 100;  head = rne_pkg::SymC; end
      5:       begin weight = 90;   head = rne_pkg::SymX; tail = rne_pkg::SymC; end
      6:       begin weight = 50;   head = rne_pkg::SymL; end
      7:       begin weight = 40;   head = rne_pkg::SymX; tail = rne_pkg::SymL; end
      8:       begin weight = 10;   head = rne_pkg::SymX; end
      9:       begin weight = 9;    head = rne_pkg::SymI; tail = rne_pkg::SymX; end
      10:      begin weight = 5;    head = rne_pkg::SymV; end
      11:      begin weight = 4;    head = rne_pkg::SymI; tail = rne_pkg::SymV; end
      default: begin weight = 1;    head = rne_pkg::SymI; end
    endcase
  endfunction

  function automatic void queue_numeral(input logic [rne_pkg::ValueW-1:0] value);
    glyph_t                   run[$];
    glyph_t                   g;
    int unsigned              rest;
    int unsigned              weight;
    logic [rne_pkg::SymW-1:0] head;
    logic [rne_pkg::SymW-1:0] tail;
    g.last    = 1'b0;
    g.invalid = 1'b0;
    if (value == '0 || value > rne_pkg::ValueMax) begin
      g.symbol  = rne_pkg::SymNone;
      g.last    = 1'b1;
      g.invalid = 1'b1;
      glyphs.push_back(g);
      return;
    end
    rest = value;
    for (int s = 0; s < 13; s++) begin
      numeral_step(s, weight, head, tail);
      while (rest >= weight) begin
        rest -= weight;
        g.symbol = head;
        run.push_back(g);
        if (tail != rne_pkg::SymNone) begin
          g.symbol = tail;
          run.push_back(g);
        end
      end
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) glyphs.push_back(run[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : score
    glyph_t want;
    glyph_t got;
    if (!rst_ni) begin
      glyphs.delete();
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) queue_numeral(req_mon.value);
      if (chr_mon.valid && chr_mon.ready) begin
        got.symbol  = chr_mon.symbol;
        got.last    = chr_mon.last;
        got.invalid = chr_mon.invalid;
        if (glyphs.size() == 0) begin
          $display("%0t: expected no character, got symbol=%h last=%b invalid=%b",
                   $time, got.symbol, got.last, got.invalid);
          fails_o <= fails_o + 1;
        end else begin
          want = glyphs.pop_front();
          if (got !== want) begin
            $display("%0t: expected symbol=%h last=%b invalid=%b, got symbol=%h last=%b invalid=%b",
                     $time, want.symbol, want.last, want.invalid,
                     got.symbol, got.last, got.invalid);
            fails_o <= fails_o + 1;
          end
        end
      end
      pending_o <= glyphs.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top: drives integers into the Roman numeral encoder and gives the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ValW           = rne_pkg::ValueW;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned RandomPerPhase = 87;
  localparam logic [ValW-1:0] Corners [22] = '{
    12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
    12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd5, 12'd50, 12'd500,
    12'd2048, 12'd1444, 12'd3, 12'd2, 12'd1994, 12'd4094
  };

  logic        clk_i;
  logic        rst_ni;
  logic        hold_kick;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  rne_in_if  req_if ();
  rne_out_if chr_if ();

  roman_numeral_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (chr_if)
  );

  rne_checker u_numeral_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_if),
    .chr_mon   (chr_if),
    .fails_o   (fail_cnt),
    .pending_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    logic        hold_seen;
    stall_left   = 0;
    hold_seen    = 1'b0;
    chr_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_kick && !hold_seen) begin
        hold_seen  = 1'b1;
        stall_left = HoldCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        chr_if.ready <= 1'b0;
      end else begin
        chr_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return ValW'($urandom_range(4000, 4095));
    if (r < 25) return ValW'($urandom_range(1, 60));
    return ValW'($urandom_range(1, 3999));
  endfunction

  task automatic offer(input logic [ValW-1:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      req_if.value <= ValW'($urandom);
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.value <= value;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic await_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  initial begin
    rst_ni       = 1'b0;
    hold_kick    = 1'b0;
    req_if.valid = 1'b0;
    req_if.value = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Corners[i]) offer(Corners[i]);
    await_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  hold_kick = 1'b1; end
        1:       begin idle_pct = 78; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      repeat (RandomPerPhase) offer(pick_value());
      await_drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
